// ===== rtl/mpss_pkg.sv =====
// Package with the shared types and constants of the Markov profile site scanner.
`default_nettype none
package mpss_pkg;

    localparam int WINDOW_MAX    = 32;
    localparam int ORDER_MAX     = 2;
    localparam int CONTEXT_COUNT = 64;
    localparam int HIST_DEPTH    = WINDOW_MAX + ORDER_MAX;
    localparam int COL_W         = $clog2(WINDOW_MAX);
    localparam int CTX_W         = $clog2(CONTEXT_COUNT);
    localparam int ADDR_W        = COL_W + CTX_W;

    localparam logic [2:0] UNKNOWN_BASE = 3'd4;
    localparam logic       REQ_BASE     = 1'b0;
    localparam logic       REQ_WEIGHT   = 1'b1;

    // Configuration register indexes.
    localparam logic [2:0] CFG_ORDER   = 3'd0;
    localparam logic [2:0] CFG_LENGTH  = 3'd1;
    localparam logic [2:0] CFG_OFFSET  = 3'd2;
    localparam logic [2:0] CFG_RSTART  = 3'd3;
    localparam logic [2:0] CFG_REND    = 3'd4;
    localparam logic [2:0] CFG_CUTOFF  = 3'd5;
    localparam logic [2:0] CFG_MAXSITE = 3'd6;

    typedef struct packed {
        logic              req_type;
        logic [2:0]        base_code;
        logic              sequence_start;
        logic [4:0]        weight_column;
        logic [5:0]        weight_context;
        logic signed [15:0] weight_value;
    } in_item_t;

    typedef struct packed {
        logic [31:0]        site_position;
        logic signed [23:0] site_score;
        logic               limit_reached;
    } out_item_t;

    // Control shared by every cell of the base chain.
    typedef struct packed {
        logic push;
        logic load;
        logic shift;
    } cell_ctrl_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_FINISH
    } state_t;

endpackage
`default_nettype wire

// ===== rtl/mpss_cell.sv =====
// One cell of the base chain: a history base and a scan copy of it.
`default_nettype none
module mpss_cell
    import mpss_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire cell_ctrl_t ctrl,
    input  wire logic [2:0] hist_in,
    input  wire logic [2:0] scan_in,
    output logic [2:0]      hist_out,
    output logic [2:0]      scan_out
);

    logic [2:0] hist_reg, hist_next;
    logic [2:0] scan_reg, scan_next;

    // The history moves one place on each base; the scan copy is loaded or stepped.
    always_comb begin
        hist_next = ctrl.push ? hist_in : hist_reg;
        if (ctrl.load) begin
            scan_next = hist_next;
        end else if (ctrl.shift) begin
            scan_next = scan_in;
        end else begin
            scan_next = scan_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hist_reg <= UNKNOWN_BASE;
        end else begin
            hist_reg <= hist_next;
        end
    end

    always_ff @(posedge aclk) begin
        scan_reg <= scan_next;
    end

    assign hist_out = hist_reg;
    assign scan_out = scan_reg;

endmodule
`default_nettype wire

// ===== rtl/mpss_wmem.sv =====
// Weight table memory with one write port and one registered read port.
`default_nettype none
module mpss_wmem
    import mpss_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [15:0]       wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic [15:0]            rdata
);

    logic [15:0] mem [WINDOW_MAX*CONTEXT_COUNT];
    logic [15:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

// ===== rtl/markov_profile_site_scanner_top.sv =====
// A weight write or a base that starts no window keeps the block ready.
// A scored window steps through the scan, drain and finish states, with one
// weight table read per window column through the scan chain, and on a hit
// registers its result in the finish state, which waits out a stalled result.
// The block takes one item at a time. Reset clears the history to unknown bases,
// the counters, the state and the configuration registers, not the weight table.
`default_nettype none
module markov_profile_site_scanner_top
    import mpss_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    output logic           s_ready,
    input  wire in_item_t  s_data,
    output logic           m_valid,
    input  wire logic      m_ready,
    output out_item_t      m_data,
    input  wire logic      cfg_we,
    input  wire logic [2:0] cfg_idx,
    input  wire logic [31:0] cfg_wdata
);

    state_t state_reg, state_next;

    logic [1:0]         order_reg;
    logic [5:0]         length_reg;
    logic [7:0]         offset_reg;
    logic [31:0]        rstart_reg;
    logic [31:0]        rend_reg;
    logic signed [23:0] cutoff_reg;
    logic [23:0]        maxsite_reg;

    logic [31:0]        cnt_reg;
    logic [23:0]        sites_reg;
    logic [COL_W-1:0]   col_reg;
    logic               ok_reg;
    logic signed [23:0] acc_reg;
    logic               pend_reg;
    logic [31:0]        pos_reg;
    logic               m_valid_reg;
    out_item_t          out_reg;

    logic accept, base_acc, win, issue, emit, hit;
    logic [31:0] cnt_eff;
    logic [23:0] sites_eff;
    logic [5:0]  len6;
    logic [1:0]  ord;
    logic signed [33:0] start_pos, left_b, left_raw, right_b;
    logic in_win;

    cell_ctrl_t ctrl;
    logic [2:0] hist  [HIST_DEPTH];
    logic [2:0] scan  [HIST_DEPTH];
    logic [2:0] h_in  [HIST_DEPTH];
    logic [2:0] s_in  [HIST_DEPTH];

    logic [CTX_W-1:0]  ctx;
    logic              bad;
    logic [15:0]       rdata;

    assign accept   = s_valid && s_ready;
    assign base_acc = accept && (s_data.req_type == REQ_BASE);

    // Window bounds for the base being taken in.
    always_comb begin
        cnt_eff   = s_data.sequence_start ? 32'd0 : cnt_reg;
        sites_eff = s_data.sequence_start ? 24'd0 : sites_reg;
        len6      = (length_reg > 6'(WINDOW_MAX)) ? 6'(WINDOW_MAX) : length_reg;
        ord       = (order_reg > 2'(ORDER_MAX)) ? 2'(ORDER_MAX) : order_reg;
        start_pos = $signed({2'b00, cnt_eff}) - $signed({28'd0, len6}) + 34'sd1;
        left_raw  = $signed({2'b00, rstart_reg}) - $signed({26'd0, offset_reg});
        left_b    = (left_raw < $signed({32'd0, ord})) ? $signed({32'd0, ord}) : left_raw;
        right_b   = $signed({2'b00, rend_reg}) - $signed({26'd0, offset_reg});
        in_win    = (len6 != 6'd0) && (start_pos >= left_b) && (start_pos <= right_b)
                    && (sites_eff < maxsite_reg);
    end

    assign win = base_acc && in_win;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            order_reg   <= 2'd0;
            length_reg  <= 6'd1;
            offset_reg  <= 8'd0;
            rstart_reg  <= 32'd0;
            rend_reg    <= 32'hFFFF_FFFF;
            cutoff_reg  <= 24'sd0;
            maxsite_reg <= 24'hFF_FFFF;
        end else if (cfg_we) begin
            unique case (cfg_idx)
                CFG_ORDER:   order_reg   <= cfg_wdata[1:0];
                CFG_LENGTH:  length_reg  <= cfg_wdata[5:0];
                CFG_OFFSET:  offset_reg  <= cfg_wdata[7:0];
                CFG_RSTART:  rstart_reg  <= cfg_wdata;
                CFG_REND:    rend_reg    <= cfg_wdata;
                CFG_CUTOFF:  cutoff_reg  <= $signed(cfg_wdata[23:0]);
                CFG_MAXSITE: maxsite_reg <= cfg_wdata[23:0];
                default: ;
            endcase
        end
    end

    // Chain of base cells.
    assign ctrl.push  = base_acc;
    assign ctrl.load  = base_acc;
    assign ctrl.shift = issue;

    for (genvar k = 0; k < HIST_DEPTH; k++) begin : g_cell
        if (k == 0) begin : g_head
            assign h_in[k] = s_data.base_code;
        end else begin : g_body
            assign h_in[k] = s_data.sequence_start ? UNKNOWN_BASE : hist[k-1];
        end
        if (k == HIST_DEPTH - 1) begin : g_top
            assign s_in[k] = UNKNOWN_BASE;
        end else begin : g_below
            assign s_in[k] = scan[k+1];
        end
        mpss_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .ctrl     (ctrl),
            .hist_in  (h_in[k]),
            .scan_in  (s_in[k]),
            .hist_out (hist[k]),
            .scan_out (scan[k])
        );
    end

    // Context of the current column from the head of the scan chain.
    always_comb begin
        case (ord)
            2'd0:    ctx = {4'd0, scan[0][1:0]};
            2'd1:    ctx = {2'd0, scan[1][1:0], scan[0][1:0]};
            default: ctx = {scan[2][1:0], scan[1][1:0], scan[0][1:0]};
        endcase
        bad = scan[0][2] || ((ord >= 2'd1) && scan[1][2]) || ((ord == 2'd2) && scan[2][2]);
    end

    mpss_wmem u_wmem (
        .aclk  (aclk),
        .we    (accept && (s_data.req_type != REQ_BASE)),
        .waddr ({s_data.weight_column, s_data.weight_context}),
        .wdata (s_data.weight_value),
        .raddr ({col_reg, ctx}),
        .rdata (rdata)
    );

    assign hit = ok_reg && (acc_reg >= cutoff_reg);

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (win) state_next = ST_SCAN;
            ST_SCAN:   if (col_reg == '0) state_next = ST_DRAIN;
            ST_DRAIN:  state_next = ST_FINISH;
            ST_FINISH: if (!hit || !m_valid_reg || m_ready) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // State outputs.
    always_comb begin
        s_ready = 1'b0;
        issue   = 1'b0;
        emit    = 1'b0;
        unique case (state_reg)
            ST_IDLE:   s_ready = 1'b1;
            ST_SCAN:   issue   = 1'b1;
            ST_DRAIN:  ;
            ST_FINISH: emit    = hit && (!m_valid_reg || m_ready);
            default:   ;
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= 32'd0;
            sites_reg   <= 24'd0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            pend_reg  <= issue;
            if (base_acc) begin
                cnt_reg <= cnt_eff + 32'd1;
            end
            if (base_acc && s_data.sequence_start) begin
                sites_reg <= 24'd0;
            end else if (emit) begin
                sites_reg <= sites_reg + 24'd1;
            end
            if (emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Scoring datapath.
    always_ff @(posedge aclk) begin
        if (win) begin
            col_reg <= COL_W'(len6 - 6'd1);
            ok_reg  <= 1'b1;
            acc_reg <= 24'sd0;
            pos_reg <= 32'(start_pos + $signed({26'd0, offset_reg}));
        end else begin
            if (issue) begin
                col_reg <= col_reg - COL_W'(1);
                ok_reg  <= ok_reg && !bad;
            end
            if (pend_reg) begin
                acc_reg <= acc_reg + 24'($signed(rdata));
            end
        end
        if (emit) begin
            out_reg.site_position <= pos_reg;
            out_reg.site_score    <= acc_reg;
            out_reg.limit_reached <= ((sites_reg + 24'd1) == maxsite_reg);
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

endmodule
`default_nettype wire

// ===== rtl/mpss_checker.sv =====
// Port checker for the site scanner and its binding to the top level.
`default_nettype none
module mpss_checker
    import mpss_pkg::*;
(
    input wire logic      aclk,
    input wire logic      aresetn,
    input wire logic      s_valid,
    input wire logic      s_ready,
    input wire in_item_t  s_data,
    input wire logic      m_valid,
    input wire logic      m_ready,
    input wire out_item_t m_data
);

    // A waiting result item stays.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result item dropped while stalled");

    // A weight write item never produces a result.
    a_write: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_data.req_type != REQ_BASE) && !m_valid |=> !m_valid)
        else $error("weight write produced a result item");

    // No result item straight after reset.
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result item valid after reset");

    // A stalled result item keeps its value while the block is busy.
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready && !s_ready |=> m_valid && $stable(m_data))
        else $error("result item changed while the block was busy");

endmodule

bind markov_profile_site_scanner_top mpss_checker u_mpss_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
`default_nettype wire

// ===== tb/site_checker.sv =====
// Checker that watches both channels of the site scanner, predicts sites and compares them.
module site_checker
    import mpss_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    input  wire logic        s_ready,
    input  wire in_item_t    s_data,
    input  wire logic        m_valid,
    input  wire logic        m_ready,
    input  wire out_item_t   m_data,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_idx,
    input  wire logic [31:0] cfg_wdata,
    output int               fail_count,
    output int               pending_sites,
    output int               sites_seen
);

    // Shadow copy of the registers and the scanner state.
    logic [1:0]         order_q;
    logic [5:0]         length_q;
    logic [7:0]         offset_q;
    logic [31:0]        rstart_q;
    logic [31:0]        rend_q;
    logic signed [23:0] cutoff_q;
    logic [23:0]        maxsite_q;
    logic [2:0]         history [HIST_DEPTH];
    logic signed [15:0] weights [WINDOW_MAX*CONTEXT_COUNT];
    logic [31:0]        position_q;
    logic [23:0]        found_q;
    out_item_t          site_queue [$];

    assign pending_sites = site_queue.size();

    // Advances the shadow state by one accepted base and predicts its site, if any.
    task automatic scan_base(input in_item_t it);
        int unsigned ord, len;
        longint pos, start, left, right, score;
        int unsigned ctx;
        logic [2:0] b;
        bit ok;
        out_item_t site;
        if (it.sequence_start) begin
            foreach (history[k]) history[k] = UNKNOWN_BASE;
            position_q = '0;
            found_q = '0;
        end
        for (int k = HIST_DEPTH - 1; k > 0; k--) history[k] = history[k-1];
        history[0] = it.base_code;
        pos = longint'(position_q);
        position_q = position_q + 32'd1;
        ord = (order_q > ORDER_MAX) ? ORDER_MAX : order_q;
        len = (length_q > WINDOW_MAX) ? WINDOW_MAX : length_q;
        if (len == 0) return;
        start = pos - longint'(len) + 1;
        left = longint'(rstart_q) - longint'(offset_q);
        if (left < longint'(ord)) left = ord;
        right = longint'(rend_q) - longint'(offset_q);
        if (start < left || start > right) return;
        if (found_q >= maxsite_q) return;
        score = 0;
        ok = 1;
        for (int unsigned i = 0; i < len && ok; i++) begin
            ctx = 0;
            for (int unsigned j = 0; j <= ord; j++) begin
                b = history[len - 1 - i + ord - j];
                if (b >= UNKNOWN_BASE) ok = 0;
                ctx = ctx * 4 + b[1:0];
            end
            if (ok && ctx < CONTEXT_COUNT) score += weights[i*CONTEXT_COUNT + ctx];
            else ok = 0;
        end
        if (!ok || score < longint'(cutoff_q)) return;
        found_q = found_q + 24'd1;
        site.site_position = 32'(start + longint'(offset_q));
        site.site_score = 24'(score);
        site.limit_reached = (found_q == maxsite_q);
        site_queue.push_back(site);
    endtask

    // Tracks every accepted item and configuration write, and compares each site.
    always @(posedge aclk) begin
        out_item_t want;
        if (!aresetn) begin
            order_q <= 2'd0; length_q <= 6'd1; offset_q <= 8'd0; rstart_q <= '0;
            rend_q <= '1; cutoff_q <= '0; maxsite_q <= '1;
            foreach (history[k]) history[k] = UNKNOWN_BASE;
            position_q = '0; found_q = '0;
            fail_count <= 0;
            sites_seen <= 0;
        end else begin
            if (cfg_we) begin
                case (cfg_idx)
                    CFG_ORDER:   order_q   <= cfg_wdata[1:0];
                    CFG_LENGTH:  length_q  <= cfg_wdata[5:0];
                    CFG_OFFSET:  offset_q  <= cfg_wdata[7:0];
                    CFG_RSTART:  rstart_q  <= cfg_wdata;
                    CFG_REND:    rend_q    <= cfg_wdata;
                    CFG_CUTOFF:  cutoff_q  <= cfg_wdata[23:0];
                    CFG_MAXSITE: maxsite_q <= cfg_wdata[23:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                if (s_data.req_type != REQ_BASE)
                    weights[{s_data.weight_column, s_data.weight_context}] = s_data.weight_value;
                else
                    scan_base(s_data);
            end
            if (m_valid && m_ready) begin
                sites_seen <= sites_seen + 1;
                if (site_queue.size() == 0) begin
                    if (fail_count < 10)
                        $display("Unexpected site: pos %0d score %0d limit %0d",
                                 m_data.site_position, m_data.site_score, m_data.limit_reached);
                    fail_count <= fail_count + 1;
                end else begin
                    want = site_queue.pop_front();
                    if (want !== m_data) begin
                        if (fail_count < 10)
                            $display({"Site mismatch: expected pos %0d score %0d limit %0d,",
                                      " got pos %0d score %0d limit %0d"},
                                     want.site_position, want.site_score, want.limit_reached,
                                     m_data.site_position, m_data.site_score,
                                     m_data.limit_reached);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

// ===== tb/testbench.sv =====
// Top of the site scanner testbench: clock, reset, stimulus, stalls and the verdict.
module testbench
    import mpss_pkg::*;
();

    localparam int WATCHDOG_LIMIT = 20000;

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_valid = 0;
    logic        s_ready;
    in_item_t    s_data = '0;
    logic        m_valid;
    logic        m_ready = 0;
    out_item_t   m_data;
    logic        cfg_we = 0;
    logic [2:0]  cfg_idx = '0;
    logic [31:0] cfg_wdata = '0;
    int          fail_count, pending_sites, sites_seen;
    int          idle_cycles = 0;
    int          items_sent = 0;
    int          phases_run = 0;
    bit          hold_off = 0;
    bit          random_stalls = 0;

    always begin
        #4 aclk = 1;
        #4 aclk = 0;
    end

    markov_profile_site_scanner_top u_top (
        .aclk, .aresetn, .s_valid, .s_ready, .s_data, .m_valid, .m_ready, .m_data,
        .cfg_we, .cfg_idx, .cfg_wdata
    );

    site_checker u_checker (
        .aclk, .aresetn, .s_valid, .s_ready, .s_data, .m_valid, .m_ready, .m_data,
        .cfg_we, .cfg_idx, .cfg_wdata, .fail_count, .pending_sites, .sites_seen
    );

    // Receiver: random stall pattern or always ready, with a long hold-off when asked.
    always @(posedge aclk) begin
        if (hold_off) m_ready <= 0;
        else if (random_stalls) m_ready <= ($urandom_range(0, 3) != 0);
        else m_ready <= 1;
    end

    // Watchdog on cycles without any accepted item, result or register write.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || cfg_we) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog expired with %0d sites outstanding", pending_sites);
            $display("Regression FAIL");
            $finish;
        end
    end

    // Offers one item and waits for it to be accepted. Valid stays high so that a
    // following item can go straight after; a gap or a drain drops it.
    task automatic send_item(input in_item_t it);
        s_valid <= 1'b1;
        s_data <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        items_sent++;
    endtask

    task automatic write_weight(input int col, input int ctx, input int value);
        in_item_t it;
        it = '0;
        it.req_type = REQ_WEIGHT;
        it.base_code = 3'($urandom);
        it.sequence_start = 1'($urandom_range(0, 1));
        it.weight_column = 5'(col);
        it.weight_context = 6'(ctx);
        it.weight_value = 16'(value);
        send_item(it);
    endtask

    // A base item; the weight fields carry random noise.
    task automatic send_base(input int code, input bit first);
        in_item_t it;
        it = in_item_t'($urandom);
        it.req_type = REQ_BASE;
        it.base_code = 3'(code);
        it.sequence_start = first;
        send_item(it);
    endtask

    // Stops offering and waits until every predicted site has come, plus the scoring latency.
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_sites != 0) @(posedge aclk);
        repeat (WINDOW_MAX + 8) @(posedge aclk);
    endtask

    // Writes one register; the caller drops the write enable after the last one.
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        cfg_we <= 1;
        cfg_idx <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
    endtask

    // Fills the entries that later settings read: every context for the first columns,
    // order-one contexts further on and order-zero contexts up to the last column given.
    task automatic fill_weights(input int spread, input int wide_cols, input int mid_cols,
                                input int narrow_cols);
        int span;
        for (int c = 0; c < WINDOW_MAX; c++) begin
            span = (c < wide_cols) ? CONTEXT_COUNT : (c < mid_cols) ? 16 :
                   (c < narrow_cols) ? 4 : 0;
            for (int x = 0; x < span; x++)
                write_weight(c, x, int'($urandom_range(0, 2*spread)) - spread);
        end
    endtask

    // One phase: a register setting followed by random sequences.
    task automatic run_phase(input int count, input int order, input int len,
                             input int offset, input logic [31:0] rs, input logic [31:0] re,
                             input int cutoff, input int maxs);
        int code;
        drain();
        write_reg(CFG_ORDER, order);
        write_reg(CFG_LENGTH, len);
        write_reg(CFG_OFFSET, offset);
        write_reg(CFG_RSTART, rs);
        write_reg(CFG_REND, re);
        write_reg(CFG_CUTOFF, cutoff);
        write_reg(CFG_MAXSITE, maxs);
        cfg_we <= 0;
        phases_run++;
        for (int n = 0; n < count; n++) begin
            // Bursts with random gaps; occasionally a weight rewrite as noise.
            if ($urandom_range(0, 15) == 0) begin
                s_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge aclk);
            end
            if ($urandom_range(0, 30) == 0)
                write_weight($urandom_range(0, WINDOW_MAX - 1),
                             $urandom_range(0, CONTEXT_COUNT - 1),
                             int'($urandom_range(0, 65535)) - 32768);
            code = ($urandom_range(0, 40) == 0) ? $urandom_range(4, 7) : $urandom_range(0, 3);
            send_base(code, (n == 0) || ($urandom_range(0, 120) == 0));
        end
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);
        random_stalls = 1;

        // Directed: extreme weights, then short windows with unknown bases.
        fill_weights(32767, 3, 4, 4);
        write_weight(0, 0, 32767);
        write_weight(31, 63, -32768);
        run_phase(12, 0, 1, 0, 0, 32'hFFFF_FFFF, -8388608, 16777215);
        run_phase(10, 2, 3, 255, 300, 32'hFFFF_FFFF, -8388608, 3);
        run_phase(8, 3, 0, 0, 0, 32'hFFFF_FFFF, 0, 5);

        // Long hold-off of the receiver while the sender keeps offering.
        fork
            begin
                hold_off = 1;
                repeat (300) @(posedge aclk);
                hold_off = 0;
            end
            run_phase(60, 1, 4, 0, 0, 32'hFFFF_FFFF, -8388608, 16777215);
        join

        // Random phases over several settings, extremes included.
        fill_weights(400, 6, 12, WINDOW_MAX);
        run_phase(160, 0, 8, 3, 0, 32'hFFFF_FFFF, 0, 16777215);
        run_phase(160, 1, 12, 0, 10, 200, -2000, 16777215);
        run_phase(160, 0, 63, 255, 0, 32'hFFFF_FFFF, 1500, 16777215);
        run_phase(160, 2, 5, 7, 20, 100, -8388608, 0);
        run_phase(160, 1, 2, 0, 0, 32'hFFFF_FFFF, 8388607, 16777215);
        run_phase(160, 0, 1, 0, 0, 32'hFFFF_FFFF, -100, 4);

        // Sender pauses until every expected site has come.
        drain();
        random_stalls = 0;
        run_phase(80, 2, 6, 1, 0, 32'hFFFF_FFFF, -500, 16777215);
        drain();

        $display("Sent %0d items over %0d register settings; %0d sites checked.",
                 items_sent, phases_run, sites_seen);
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("%0d mismatches", fail_count);
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
